// File: rtl/bpi_pkg.sv
// bpi_pkg: shared constants, state types and control structs for the
// breakpoint interpolator. No dependencies.
package bpi_pkg;

   localparam int MAX_POINTS_DEFAULT = 8;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int CSR_BITS = 4;
   localparam int IDX_BITS = 3;
   localparam logic [CSR_BITS-1:0] POINTS_RESET = 4'd8;
   localparam logic [CSR_BITS-1:0] POINTS_MIN   = 4'd3;

   // multiplier operand slice handled per cycle
   localparam int MUL_CHUNK = 16;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DECIDE,
      BK_START,
      BK_WAIT,
      BK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      AR_IDLE,
      AR_MUL,
      AR_CHECK,
      AR_DIV,
      AR_FIN
   } arith_state_type;

   typedef struct packed {
      logic start;
      logic neg;
   } arith_req_type;

endpackage

// File: rtl/bpi_ram.sv
// bpi_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module bpi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bpi_arith.sv
// bpi_arith: sequential multiply (16-bit slices) and radix-2 restoring divide,
// then signed add and saturation. Depends on bpi_pkg.
module bpi_arith #(
   parameter int VALUE_BITS = bpi_pkg::VALUE_BITS_DEFAULT,
   localparam int MW = VALUE_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bpi_pkg::arith_req_type       req,
   input  logic [MW-1:0]                mag_a,
   input  logic [MW-1:0]                mag_b,
   input  logic [MW-1:0]                mag_d,
   input  logic [VALUE_BITS-1:0]        y_left,
   output logic                         done,
   output logic [VALUE_BITS-1:0]        y_result
);

   localparam int W    = VALUE_BITS;
   localparam int PW   = 2 * VALUE_BITS + 1;
   localparam int CH   = bpi_pkg::MUL_CHUNK;
   localparam int NCH  = (MW + bpi_pkg::MUL_CHUNK - 1) / bpi_pkg::MUL_CHUNK;
   localparam int BPAD = NCH * bpi_pkg::MUL_CHUNK;
   localparam int CW   = $clog2(MW + 1);
   localparam int SW   = VALUE_BITS + 3;

   bpi_pkg::arith_state_type state_ff, state_in;

   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [MW-1:0]   a_ff, a_in;
   logic [BPAD-1:0] b_ff, b_in;
   logic [MW-1:0]   d_ff, d_in;
   logic            neg_ff, neg_in;
   logic [W-1:0]    yl_ff, yl_in;
   logic [PW-1:0]   acc_ff, acc_in;
   logic [MW-1:0]   rem_ff, rem_in;
   logic [MW-1:0]   nq_ff, nq_in;
   logic            sat_ff, sat_in;
   logic [W-1:0]    y_ff, y_in;
   logic            done_ff, done_in;

   logic do_load, do_mul, do_check, do_div, do_fin;

   logic [MW+CH-1:0] prod;
   logic             over_now;
   logic [MW:0]      trial;
   logic             trial_ge;
   logic [MW:0]      trial_diff;
   logic [SW-1:0]    sum;
   logic [SW-1:0]    q_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpi_pkg::AR_IDLE: begin
            if (req.start) state_in = bpi_pkg::AR_MUL;
         end
         bpi_pkg::AR_MUL: begin
            if (cnt_ff == CW'(NCH - 1)) state_in = bpi_pkg::AR_CHECK;
         end
         bpi_pkg::AR_CHECK: begin
            state_in = over_now ? bpi_pkg::AR_FIN : bpi_pkg::AR_DIV;
         end
         bpi_pkg::AR_DIV: begin
            if (cnt_ff == CW'(MW - 1)) state_in = bpi_pkg::AR_FIN;
         end
         bpi_pkg::AR_FIN: begin
            state_in = bpi_pkg::AR_IDLE;
         end
         default: state_in = bpi_pkg::AR_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      do_load  = 1'b0;
      do_mul   = 1'b0;
      do_check = 1'b0;
      do_div   = 1'b0;
      do_fin   = 1'b0;
      unique case (state_ff)
         bpi_pkg::AR_IDLE:  do_load  = req.start;
         bpi_pkg::AR_MUL:   do_mul   = 1'b1;
         bpi_pkg::AR_CHECK: do_check = 1'b1;
         bpi_pkg::AR_DIV:   do_div   = 1'b1;
         bpi_pkg::AR_FIN:   do_fin   = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      prod       = a_ff * b_ff[BPAD-1 -: CH];
      // quotient would not fit in MW bits: result saturates either way
      over_now   = {1'b0, acc_ff[PW-1:MW]} >= d_ff;
      trial      = {rem_ff, nq_ff[MW-1]};
      trial_ge   = trial >= {1'b0, d_ff};
      trial_diff = trial - {1'b0, d_ff};
      q_ext      = SW'(nq_ff);
      sum        = {{3{yl_ff[W-1]}}, yl_ff} + (neg_ff ? (~q_ext + 1'b1) : q_ext);

      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      yl_in   = yl_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      sat_in  = sat_ff;
      y_in    = y_ff;
      done_in = do_fin;

      if (do_load) begin
         a_in   = mag_a;
         b_in   = BPAD'(mag_b);
         d_in   = mag_d;
         neg_in = req.neg;
         yl_in  = y_left;
         acc_in = '0;
         cnt_in = '0;
      end
      if (do_mul) begin
         // most significant slice first
         acc_in = (acc_ff << CH) + PW'(prod);
         b_in   = b_ff << CH;
         cnt_in = cnt_ff + 1'b1;
      end
      if (do_check) begin
         sat_in = over_now;
         rem_in = {1'b0, acc_ff[PW-1:MW]};
         nq_in  = acc_ff[MW-1:0];
         cnt_in = '0;
      end
      if (do_div) begin
         rem_in = trial_ge ? trial_diff[MW-1:0] : trial[MW-1:0];
         nq_in  = {nq_ff[MW-2:0], trial_ge};
         cnt_in = cnt_ff + 1'b1;
      end
      if (do_fin) begin
         if (sat_ff) begin
            y_in = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end else if (sum[SW-1:W-1] == '0 || sum[SW-1:W-1] == '1) begin
            y_in = sum[W-1:0];
         end else begin
            y_in = sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpi_pkg::AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      yl_ff  <= yl_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      sat_ff <= sat_in;
      y_ff   <= y_in;
   end

   assign done     = done_ff;
   assign y_result = y_ff;

endmodule

// File: rtl/bpi_front.sv
// bpi_front: request intake, points-in-use register and command build for the
// back end queue. Depends on bpi_pkg.
module bpi_front #(
   parameter int MAX_POINTS = bpi_pkg::MAX_POINTS_DEFAULT,
   parameter int VALUE_BITS = bpi_pkg::VALUE_BITS_DEFAULT,
   localparam int AW    = $clog2(MAX_POINTS),
   localparam int CMD_W = 1 + AW + 2 * VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [bpi_pkg::IDX_BITS-1:0]  req_point_index,
   input  logic signed [VALUE_BITS-1:0]  req_point_x,
   input  logic signed [VALUE_BITS-1:0]  req_point_y,
   input  logic signed [VALUE_BITS-1:0]  req_x_in,
   input  logic                          csr_write_enable,
   input  logic [bpi_pkg::CSR_BITS-1:0]  csr_write_data,
   output logic                          q_push,
   output logic [CMD_W-1:0]              q_data,
   input  logic                          q_ready
);

   logic [bpi_pkg::CSR_BITS-1:0] points_ff, points_in;
   logic [AW-1:0]                last_idx;
   logic                         is_eval;
   logic                         write_ok;

   always_comb begin
      points_in = csr_write_enable ? csr_write_data : points_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= bpi_pkg::POINTS_RESET;
      end else begin
         points_ff <= points_in;
      end
   end

   // index of the last point in use, clamped into the table
   always_comb begin
      if (points_ff < bpi_pkg::POINTS_MIN) begin
         last_idx = AW'(bpi_pkg::POINTS_MIN - 4'd1);
      end else if (32'(points_ff) > 32'(MAX_POINTS)) begin
         last_idx = AW'(MAX_POINTS - 1);
      end else begin
         last_idx = AW'(points_ff - 4'd1);
      end
   end

   always_comb begin
      is_eval   = (req_func == bpi_pkg::FUNC_EVAL);
      write_ok  = (32'(req_point_index) < 32'(MAX_POINTS));
      req_ready = q_ready;
      // writes past the table are taken and dropped here
      q_push    = req_valid && q_ready && (is_eval || write_ok);
      q_data    = {is_eval,
                   is_eval ? last_idx : AW'(req_point_index),
                   is_eval ? req_x_in : req_point_x,
                   req_point_y};
   end

endmodule

// File: rtl/bpi_fifo.sv
// bpi_fifo: two-entry command queue between front and back end.
// No dependencies.
module bpi_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push_ok, pop_ok;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_data   = slot_ff[rd_ptr_ff];
      push_ok    = push && push_ready;
      pop_ok     = pop && pop_valid;
      wr_ptr_in  = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/bpi_back.sv
// bpi_back: point table, segment scan, case decision and result register.
// Depends on bpi_pkg, bpi_ram and bpi_arith.
module bpi_back #(
   parameter int MAX_POINTS = bpi_pkg::MAX_POINTS_DEFAULT,
   parameter int VALUE_BITS = bpi_pkg::VALUE_BITS_DEFAULT,
   localparam int AW    = $clog2(MAX_POINTS),
   localparam int CMD_W = 1 + AW + 2 * VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [CMD_W-1:0]              q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_BITS-1:0]  rsp_y_out,
   output logic                          rsp_zero_width
);

   localparam int W  = VALUE_BITS;
   localparam int MW = VALUE_BITS + 1;

   function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
      mag = v[MW-1] ? (~v + 1'b1) : v;
   endfunction

   bpi_pkg::back_state_type state_ff, state_in;

   logic          cmd_eval;
   logic [AW-1:0] cmd_addr;
   logic [W-1:0]  cmd_a, cmd_b;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [2*W-1:0] ram_rdata;
   logic [W-1:0]  rd_x;

   logic [W-1:0]  eval_x_ff, eval_x_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] k_ff, k_in;
   logic [2*W-1:0] prev_ff, prev_in;
   logic [W-1:0]  xl_ff, xl_in, yl_ff, yl_in, xr_ff, xr_in, yr_ff, yr_in;
   logic          seg_first_ff, seg_first_in;
   logic          seg_last_ff, seg_last_in;
   logic [MW-1:0] dn_ff, dn_in, dy_ff, dy_in, dd_ff, dd_in;
   logic [W-1:0]  res_y_ff, res_y_in;
   logic          res_zw_ff, res_zw_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_y_ff, rsp_y_in;
   logic          rsp_zw_ff, rsp_zw_in;

   logic          scan_hit;
   logic          x_below, x_above, direct;
   logic          out_free;

   logic          do_pop, do_scan, do_decide, do_wait, do_emit;

   bpi_pkg::arith_req_type arith_req;
   logic                   arith_done;
   logic [W-1:0]           arith_y;

   always_comb begin
      cmd_eval = q_data[CMD_W-1];
      cmd_addr = q_data[CMD_W-2 -: AW];
      cmd_a    = q_data[2*W-1:W];
      cmd_b    = q_data[W-1:0];
      rd_x     = ram_rdata[2*W-1:W];
      // right end of the segment: first point above x, or the last point
      scan_hit = (k_ff != '0) &&
                 ((k_ff < last_ff && $signed(eval_x_ff) < $signed(rd_x)) ||
                  k_ff == last_ff);
      x_below  = seg_first_ff && ($signed(eval_x_ff) < $signed(xl_ff));
      x_above  = seg_last_ff && ($signed(eval_x_ff) > $signed(xr_ff));
      direct   = x_below || x_above || (xl_ff == xr_ff);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpi_pkg::BK_IDLE: begin
            if (q_valid && cmd_eval) state_in = bpi_pkg::BK_SCAN;
         end
         bpi_pkg::BK_SCAN: begin
            if (scan_hit) state_in = bpi_pkg::BK_DECIDE;
         end
         bpi_pkg::BK_DECIDE: begin
            state_in = direct ? bpi_pkg::BK_EMIT : bpi_pkg::BK_START;
         end
         bpi_pkg::BK_START: begin
            state_in = bpi_pkg::BK_WAIT;
         end
         bpi_pkg::BK_WAIT: begin
            if (arith_done) state_in = bpi_pkg::BK_EMIT;
         end
         bpi_pkg::BK_EMIT: begin
            if (out_free) state_in = bpi_pkg::BK_IDLE;
         end
         default: state_in = bpi_pkg::BK_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      do_pop    = 1'b0;
      do_scan   = 1'b0;
      do_decide = 1'b0;
      do_wait   = 1'b0;
      do_emit   = 1'b0;
      arith_req = '0;
      unique case (state_ff)
         bpi_pkg::BK_IDLE:   do_pop    = q_valid;
         bpi_pkg::BK_SCAN:   do_scan   = 1'b1;
         bpi_pkg::BK_DECIDE: do_decide = 1'b1;
         bpi_pkg::BK_START: begin
            arith_req.start = 1'b1;
            arith_req.neg   = (dn_ff[MW-1] ^ dy_ff[MW-1] ^ dd_ff[MW-1]) &&
                              dn_ff != '0 && dy_ff != '0;
         end
         bpi_pkg::BK_WAIT:   do_wait   = arith_done;
         bpi_pkg::BK_EMIT:   do_emit   = out_free;
         default: ;
      endcase
      q_pop     = do_pop;
      ram_we    = do_pop && !cmd_eval;
      ram_raddr = do_scan ? AW'(k_ff + 1'b1) : '0;
   end

   // datapath
   always_comb begin
      eval_x_in    = eval_x_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      prev_in      = prev_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      xr_in        = xr_ff;
      yr_in        = yr_ff;
      seg_first_in = seg_first_ff;
      seg_last_in  = seg_last_ff;
      dn_in        = dn_ff;
      dy_in        = dy_ff;
      dd_in        = dd_ff;
      res_y_in     = res_y_ff;
      res_zw_in    = res_zw_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_zw_in    = rsp_zw_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (do_pop && cmd_eval) begin
         eval_x_in = cmd_a;
         last_in   = cmd_addr;
         k_in      = '0;
      end
      if (do_scan) begin
         prev_in = ram_rdata;
         k_in    = AW'(k_ff + 1'b1);
         if (scan_hit) begin
            xl_in        = prev_ff[2*W-1:W];
            yl_in        = prev_ff[W-1:0];
            xr_in        = rd_x;
            yr_in        = ram_rdata[W-1:0];
            seg_first_in = (k_ff == AW'(1));
            seg_last_in  = (k_ff == last_ff);
         end
      end
      if (do_decide) begin
         dn_in     = {eval_x_ff[W-1], eval_x_ff} - {xl_ff[W-1], xl_ff};
         dy_in     = {yr_ff[W-1], yr_ff} - {yl_ff[W-1], yl_ff};
         dd_in     = {xr_ff[W-1], xr_ff} - {xl_ff[W-1], xl_ff};
         res_y_in  = x_above ? yr_ff : yl_ff;
         res_zw_in = !x_below && !x_above && (xl_ff == xr_ff);
      end
      if (do_wait) begin
         res_y_in  = arith_y;
         res_zw_in = 1'b0;
      end
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_y_in     = res_y_ff;
         rsp_zw_in    = res_zw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpi_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eval_x_ff    <= eval_x_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      prev_ff      <= prev_in;
      xl_ff        <= xl_in;
      yl_ff        <= yl_in;
      xr_ff        <= xr_in;
      yr_ff        <= yr_in;
      seg_first_ff <= seg_first_in;
      seg_last_ff  <= seg_last_in;
      dn_ff        <= dn_in;
      dy_ff        <= dy_in;
      dd_ff        <= dd_in;
      res_y_ff     <= res_y_in;
      res_zw_ff    <= res_zw_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_zw_ff    <= rsp_zw_in;
   end

   bpi_ram #(
      .WIDTH (2 * VALUE_BITS),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (cmd_addr),
      .wdata ({cmd_a, cmd_b}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bpi_arith #(
      .VALUE_BITS (VALUE_BITS)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .req      (arith_req),
      .mag_a    (mag(dn_ff)),
      .mag_b    (mag(dy_ff)),
      .mag_d    (mag(dd_ff)),
      .y_left   (yl_ff),
      .done     (arith_done),
      .y_result (arith_y)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_y_out      = rsp_y_ff;
   assign rsp_zero_width = rsp_zw_ff;

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == bpi_pkg::BK_SCAN |-> k_ff <= last_ff)
      else $error("segment scan ran past the last point in use");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (do_pop && cmd_eval) |=> (state_ff == bpi_pkg::BK_SCAN && k_ff == '0))
      else $error("evaluate did not start the scan at point zero");

   a_arith_done_expected: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> state_ff == bpi_pkg::BK_WAIT)
      else $error("divider finished while nothing waited for it");

   a_zero_width_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpi_pkg::BK_EMIT && res_zw_ff) |-> dd_ff == '0)
      else $error("zero width flag on a segment of nonzero width");
`endif

endmodule

// File: rtl/piecewise_linear_breakpoint_interp.sv
// piecewise_linear_breakpoint_interp: top level of the breakpoint interpolator.
// Depends on bpi_pkg, bpi_front, bpi_fifo and bpi_back.
//
//   channel | ports                         | direction | moves
//   req     | req_valid / req_ready         | in        | write or evaluate item
//   rsp     | rsp_valid / rsp_ready         | out       | y_out and zero_width
//   csr     | csr_write_enable / _data      | in        | points_in_use, no wait
//
// a write item is stored in the table as it is popped. an interpolated item scans the
// table up to the right end of the chosen segment, then multiplies and divides; a clamped
// or zero width item skips the arithmetic, and the divide is skipped when the quotient
// overflows.
// reset is synchronous; points_in_use returns to 8, the table is not cleared.
// the two-entry queue and the output register let intake continue while a
// result waits on rsp_ready.
module piecewise_linear_breakpoint_interp #(
   parameter int MAX_POINTS = bpi_pkg::MAX_POINTS_DEFAULT,
   parameter int VALUE_BITS = bpi_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [bpi_pkg::IDX_BITS-1:0]  req_point_index,
   input  logic signed [VALUE_BITS-1:0]  req_point_x,
   input  logic signed [VALUE_BITS-1:0]  req_point_y,
   input  logic signed [VALUE_BITS-1:0]  req_x_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_BITS-1:0]  rsp_y_out,
   output logic                          rsp_zero_width,
   input  logic                          csr_write_enable,
   input  logic [bpi_pkg::CSR_BITS-1:0]  csr_write_data
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CMD_W = 1 + AW + 2 * VALUE_BITS;

   logic             fq_push, fq_ready;
   logic [CMD_W-1:0] fq_push_data;
   logic             bq_pop, bq_valid;
   logic [CMD_W-1:0] bq_data;

   bpi_front #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_point_index  (req_point_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_x_in         (req_x_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_push           (fq_push),
      .q_data           (fq_push_data),
      .q_ready          (fq_ready)
   );

   bpi_fifo #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fq_push),
      .push_data  (fq_push_data),
      .push_ready (fq_ready),
      .pop        (bq_pop),
      .pop_valid  (bq_valid),
      .pop_data   (bq_data)
   );

   bpi_back #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (bq_valid),
      .q_data         (bq_data),
      .q_pop          (bq_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_y_out      (rsp_y_out),
      .rsp_zero_width (rsp_zero_width)
   );

endmodule
